// File: src/tick_delay_wakeup_queue_macros.svh
// Assertion macros shared by the wake-up queue modules.
`ifndef TICK_DELAY_WAKEUP_QUEUE_MACROS_SVH
`define TICK_DELAY_WAKEUP_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define TDWQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wake-up queue check failed");
`define TDWQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wake-up queue check failed");
`else
`define TDWQ_ASSERT_IMP(label, ante, cons)
`define TDWQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/tdwq_pkg.sv
// Types, codes and constants of the tick-driven wake-up queue.
package tdwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int WAKE_LIMIT      = 32;
    localparam int REL_W           = $clog2(WAKE_LIMIT + 1);
    localparam int TICK_W          = 31;
    localparam int TASK_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int TYPE_W          = 2;
    localparam int KIND_W          = 3;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 40;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_TIME  = 2'd1,
        REQ_DELAY = 2'd2,
        REQ_UNTIL = 2'd3
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK    = 3'd0,
        KIND_TIME   = 3'd1,
        KIND_WAKE   = 3'd2,
        KIND_REJECT = 3'd3,
        KIND_FULL   = 3'd4
    } reply_kind_t;

    typedef struct packed {
        logic        load_req;
        logic        eval;
        logic        emit;
        reply_kind_t kind;
        logic        last;
        logic        tick_inc;
        logic        pop;
        logic        insert;
    } cmd_t;

    typedef struct packed {
        logic      out_free;
        req_type_t req_type;
        logic      wake_after_inc;
        logic      second_due;
        logic      reject;
        logic      full;
    } status_t;

endpackage

// File: src/tdwq_dpath.sv
// Datapath: request registers, tick counter, sorted waiter cells and result register.
`include "tick_delay_wakeup_queue_macros.svh"
module tdwq_dpath #(
    parameter int QUEUE_DEPTH = tdwq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tdwq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [tdwq_pkg::TYPE_W-1:0]     s_tuser,
    input  tdwq_pkg::cmd_t                  cmd,
    output tdwq_pkg::status_t               status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tdwq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [tdwq_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import tdwq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_type_t          type_reg;
    logic [TASK_W-1:0]  task_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_inc_val;
    logic [TICK_W-1:0]  deadline_reg;
    logic [TICK_W-1:0]  deadline_next;
    logic               reject_reg;
    logic               reject_next;
    logic [TICK_W:0]    delay_sum;
    logic [CNT_W-1:0]   count_reg;

    logic [TICK_W-1:0]  dl_reg [QUEUE_DEPTH];
    logic [TASK_W-1:0]  tk_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt;

    logic               m_valid_reg;
    logic [TASK_W-1:0]  out_task_reg;
    logic [TICK_W-1:0]  out_tick_reg;
    reply_kind_t        out_kind_reg;
    logic               out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            type_reg  <= req_type_t'(s_tuser);
            task_reg  <= s_tdata[TASK_W-1:0];
            value_reg <= s_tdata[TASK_W +: VALUE_W];
        end
        if (cmd.eval) begin
            deadline_reg <= deadline_next;
            reject_reg   <= reject_next;
        end
    end

    // Relative delays saturate; absolute deadlines before the current tick are refused.
    always_comb begin
        delay_sum = {1'b0, tick_reg} + {1'b0, value_reg[TICK_W-1:0]};
        if (type_reg == REQ_DELAY) begin
            reject_next   = value_reg[VALUE_W-1];
            deadline_next = delay_sum[TICK_W] ? TICK_MAX : delay_sum[TICK_W-1:0];
        end else begin
            reject_next   = value_reg[VALUE_W-1] || (value_reg[TICK_W-1:0] < tick_reg);
            deadline_next = value_reg[TICK_W-1:0];
        end
    end

    assign tick_inc_val = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.tick_inc) begin
                tick_reg <= tick_inc_val;
            end
            if (cmd.insert) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Each cell compares against the new deadline; cells past the insertion point shift up.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic              first;
        logic              prev_gt;
        logic [TICK_W-1:0] prev_dl;
        logic [TASK_W-1:0] prev_tk;
        logic [TICK_W-1:0] next_dl;
        logic [TASK_W-1:0] next_tk;

        assign gt[i] = (IDX < count_reg) && (dl_reg[i] > deadline_reg);

        if (i == 0) begin : g_head
            assign first   = gt[i];
            assign prev_gt = 1'b0;
            assign prev_dl = deadline_reg;
            assign prev_tk = task_reg;
        end else begin : g_body
            assign first   = gt[i] && !gt[i-1];
            assign prev_gt = gt[i-1];
            assign prev_dl = dl_reg[i-1];
            assign prev_tk = tk_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next_dl = dl_reg[i];
            assign next_tk = tk_reg[i];
        end else begin : g_mid
            assign next_dl = dl_reg[i+1];
            assign next_tk = tk_reg[i+1];
        end

        // The cell just past the last valid one takes the old tail when the queue shifts.
        always_ff @(posedge aclk) begin
            if (cmd.insert && (first || (!prev_gt && IDX == count_reg))) begin
                dl_reg[i] <= deadline_reg;
                tk_reg[i] <= task_reg;
            end else if (cmd.insert && (gt[i] || prev_gt)) begin
                dl_reg[i] <= prev_dl;
                tk_reg[i] <= prev_tk;
            end else if (cmd.pop) begin
                dl_reg[i] <= next_dl;
                tk_reg[i] <= next_tk;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_task_reg <= (cmd.kind == KIND_WAKE) ? tk_reg[0] : task_reg;
            out_tick_reg <= tick_reg;
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
        end
    end

    assign status.out_free       = !m_valid_reg || m_tready;
    assign status.req_type       = type_reg;
    assign status.wake_after_inc = (count_reg != '0) && (dl_reg[0] <= tick_inc_val);
    assign status.second_due     = (count_reg > CNT_W'(1)) && (dl_reg[1] <= tick_reg);
    assign status.reject         = reject_reg;
    assign status.full           = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_tick_reg, out_task_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `TDWQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `TDWQ_ASSERT_IMP(a_pop_nonempty, cmd.pop, count_reg != '0)
    `TDWQ_ASSERT_IMP(a_head_sorted, count_reg > CNT_W'(1), dl_reg[0] <= dl_reg[1])
    `TDWQ_ASSERT_NXT(a_tick_monotonic, 1'b1, tick_reg >= $past(tick_reg))

endmodule

// File: src/tdwq_ctrl.sv
// Controller state machine that sequences replies, wake-ups and insertions.
`include "tick_delay_wakeup_queue_macros.svh"
module tdwq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tdwq_pkg::status_t status,
    output tdwq_pkg::cmd_t    cmd
);
    import tdwq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_ACK     = 6'b000100,
        S_WAKE    = 6'b001000,
        S_REPLY   = 6'b010000,
        S_DISPOSE = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [REL_W-1:0]  rel_reg;
    logic [REL_W-1:0]  rel_next;
    logic              wake_last;

    // A wake-up is the last one when the per-tick limit is reached or the next waiter is not due.
    assign wake_last = (rel_reg == REL_W'(WAKE_LIMIT - 1)) || !status.second_due;

    always_comb begin
        state_next   = state_reg;
        rel_next     = rel_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.kind     = KIND_ACK;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.eval = 1'b1;
                case (status.req_type)
                    REQ_TICK:              state_next = S_ACK;
                    REQ_TIME:              state_next = S_REPLY;
                    REQ_DELAY, REQ_UNTIL:  state_next = S_DISPOSE;
                    default:               state_next = S_IDLE;
                endcase
            end
            S_ACK: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = KIND_ACK;
                    cmd.last     = !status.wake_after_inc;
                    cmd.tick_inc = 1'b1;
                    rel_next     = '0;
                    state_next   = status.wake_after_inc ? S_WAKE : S_IDLE;
                end
            end
            S_WAKE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_WAKE;
                    cmd.last   = wake_last;
                    cmd.pop    = 1'b1;
                    rel_next   = rel_reg + 1'b1;
                    state_next = wake_last ? S_IDLE : S_WAKE;
                end
            end
            S_REPLY: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_TIME;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DISPOSE: begin
                if (status.reject || status.full) begin
                    if (status.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = status.reject ? KIND_REJECT : KIND_FULL;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.insert = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rel_reg   <= rel_next;
        end
    end

    `TDWQ_ASSERT_IMP(a_rel_bound, 1'b1, rel_reg <= REL_W'(WAKE_LIMIT))
    `TDWQ_ASSERT_IMP(a_insert_legal, cmd.insert, !status.reject && !status.full)
    `TDWQ_ASSERT_NXT(a_wake_exit, state_reg == S_WAKE, state_reg == S_WAKE || state_reg == S_IDLE)

endmodule

// File: src/tick_delay_wakeup_queue.sv
// Tick-driven wake-up queue: top level joining controller and datapath.
//
// Input channel (s_*): one request item per handshake. s_tuser carries the
// request type (tick, time query, relative delay, delay until a tick);
// s_tdata carries the task id and the 32-bit signed tick value.
// Result channel (m_*): reply items with the target task, the reply kind on
// m_tuser and the current tick; m_tlast marks the final reply of a request.
//
// Each request is handled on its own. A time query passes the decode and
// reply states before its reply; a delay is decoded and then either queued
// with no reply or refused with a reject or full reply. A tick gives its ack
// from the ack state, then one wake-up per cycle while the result register is
// free, at most 32; each wake-up pops the head cell of the sorted register queue.
// A new request is taken in the cycle after the last reply is registered,
// while that reply may still wait on m_tready.
// A stalled receiver holds the block: the result register keeps its item and
// no further reply or wake-up is produced until it is taken.
// Reset clears the tick counter and the waiter count; no queued waiter
// survives it, and the controller resets to its idle state, ready for a request.
module tick_delay_wakeup_queue
    import tdwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // task_id[7:0], tick_value[39:8]
    input  logic [TYPE_W-1:0]    s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // reply_task[7:0], reply_tick[38:8], zero[39]
    output logic [KIND_W-1:0]    m_tuser,   // reply_kind[2:0]
    output logic                 m_tlast
);

    cmd_t    cmd;
    status_t status;

    tdwq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdwq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/tick_delay_wakeup_queue_test.sv
// Self-checking testbench for the tick-driven wake-up queue with a built-in predictor.
module tick_delay_wakeup_queue_test;
    import tdwq_pkg::*;

    typedef struct {
        logic [TASK_W-1:0] who;
        reply_kind_t       kind;
        logic [TICK_W-1:0] tick;
        logic              last;
    } reply_t;

    typedef struct {
        logic [TICK_W-1:0] deadline;
        logic [TASK_W-1:0] who;
    } sleeper_t;

    typedef struct {
        req_type_t          op;
        logic [TASK_W-1:0]  who;
        logic [VALUE_W-1:0] value;
        int                 copies;
        logic               typed;
        reply_kind_t        exp_kind;
        logic [TICK_W-1:0]  exp_tick;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // task_id[7:0], tick_value[39:8]
    logic [TYPE_W-1:0]    s_tuser;   // req_type[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // reply_task[7:0], reply_tick[38:8], zero[39]
    logic [KIND_W-1:0]    m_tuser;   // reply_kind[2:0]
    logic                 m_tlast;

    // Predictor state: the tick counter and the waiters sorted by deadline.
    logic [TICK_W-1:0] now_tick;
    sleeper_t          sleepers[$];
    reply_t            step_replies[$];
    reply_t            replies_due[$];
    reply_t            oldest;
    int                errors;
    logic              calm;

    stim_row_t directed_rows[21];

    tick_delay_wakeup_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Works out the replies that one accepted request causes and updates the state.
    task automatic predict_replies(input req_type_t op, input logic [TASK_W-1:0] who,
                                   input logic [VALUE_W-1:0] value);
        int                freed;
        int                pos;
        logic [TICK_W-1:0] deadline;
        logic              refuse;
        step_replies.delete();
        freed = 0;
        case (op)
            REQ_TICK: begin
                step_replies.push_back('{who: who, kind: KIND_ACK, tick: now_tick, last: 1'b0});
                if (now_tick != TICK_MAX)
                    now_tick = now_tick + 1'b1;
                while (freed < sleepers.size() && freed < WAKE_LIMIT &&
                       sleepers[freed].deadline <= now_tick) begin
                    step_replies.push_back('{who: sleepers[freed].who, kind: KIND_WAKE,
                                             tick: now_tick, last: 1'b0});
                    freed++;
                end
                repeat (freed) void'(sleepers.pop_front());
            end
            REQ_TIME: begin
                step_replies.push_back('{who: who, kind: KIND_TIME, tick: now_tick, last: 1'b0});
            end
            default: begin
                if (op == REQ_DELAY) begin
                    refuse = value[VALUE_W-1];
                    deadline = (value[TICK_W-1:0] > TICK_MAX - now_tick) ?
                               TICK_MAX : now_tick + value[TICK_W-1:0];
                end else begin
                    refuse = value[VALUE_W-1] || (value[TICK_W-1:0] < now_tick);
                    deadline = value[TICK_W-1:0];
                end
                if (refuse) begin
                    step_replies.push_back('{who: who, kind: KIND_REJECT, tick: now_tick,
                                             last: 1'b0});
                end else if (sleepers.size() >= QUEUE_DEPTH_DEF) begin
                    step_replies.push_back('{who: who, kind: KIND_FULL, tick: now_tick,
                                             last: 1'b0});
                end else begin
                    // Equal deadlines keep arrival order, so insert after them.
                    pos = sleepers.size();
                    while (pos > 0 && sleepers[pos-1].deadline > deadline)
                        pos--;
                    sleepers.insert(pos, '{deadline: deadline, who: who});
                end
            end
        endcase
        if (step_replies.size() > 0)
            step_replies[step_replies.size()-1].last = 1'b1;
    endtask

    // Offers one request item and records the replies it should cause once accepted.
    task automatic send_request(input req_type_t op, input logic [TASK_W-1:0] who,
                                input logic [VALUE_W-1:0] value, input logic typed,
                                input reply_kind_t typed_kind,
                                input logic [TICK_W-1:0] typed_tick, input logic drain);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (drain || gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            if (drain) begin
                do @(negedge aclk); while (replies_due.size() != 0);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, who};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predict_replies(op, who, value);
        if (typed) begin
            step_replies.delete();
            step_replies.push_back('{who: who, kind: typed_kind, tick: typed_tick, last: 1'b1});
        end
        foreach (step_replies[k])
            replies_due.push_back(step_replies[k]);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: reply with none pending: expected nothing, actual task %h kind %0d tick %0d last %b",
                         $time, m_tdata[7:0], m_tuser, m_tdata[38:8], m_tlast);
                errors++;
            end else begin
                oldest = replies_due.pop_front();
                if (m_tdata[7:0] !== oldest.who || m_tuser !== oldest.kind ||
                    m_tdata[38:8] !== oldest.tick || m_tlast !== oldest.last) begin
                    $display("%0t: reply mismatch: expected task %h kind %0d tick %0d last %b, actual task %h kind %0d tick %0d last %b",
                             $time, oldest.who, oldest.kind, oldest.tick, oldest.last,
                             m_tdata[7:0], m_tuser, m_tdata[38:8], m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin : receiver
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int                 roll;
        int                 tick_share;
        req_type_t          op;
        logic [TASK_W-1:0]  who;
        logic [VALUE_W-1:0] value;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        errors   = 0;
        calm     = 1'b0;
        now_tick = '0;

        directed_rows = '{
            '{REQ_TIME,  8'h00, 32'h0000_0000,  1, 1'b1, KIND_TIME,   31'd0},
            '{REQ_TICK,  8'hFF, 32'hFFFF_FFFF,  1, 1'b1, KIND_ACK,    31'd0},
            '{REQ_DELAY, 8'h80, 32'hFFFF_FFFF,  1, 1'b1, KIND_REJECT, 31'd1},
            '{REQ_DELAY, 8'h7F, 32'h8000_0000,  1, 1'b1, KIND_REJECT, 31'd1},
            '{REQ_UNTIL, 8'h01, 32'h0000_0000,  1, 1'b1, KIND_REJECT, 31'd1},
            '{REQ_UNTIL, 8'h02, 32'h8000_0000,  1, 1'b1, KIND_REJECT, 31'd1},
            // A deadline equal to the current tick is queued and fires on the next tick.
            '{REQ_UNTIL, 8'h03, 32'h0000_0001,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_DELAY, 8'hA5, 32'h0000_0000,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_DELAY, 8'h40, 32'h0000_0002,  2, 1'b0, KIND_ACK,    31'd0},
            '{REQ_UNTIL, 8'h10, 32'h0000_0003,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_TICK,  8'h20, 32'h0000_0000,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_TICK,  8'h21, 32'h7FFF_FFFF,  1, 1'b0, KIND_ACK,    31'd0},
            // Fill the queue, bounce two requests off it, then release all at once.
            '{REQ_DELAY, 8'h30, 32'h0000_0000, 32, 1'b0, KIND_ACK,    31'd0},
            '{REQ_DELAY, 8'hEE, 32'h0000_0005,  1, 1'b1, KIND_FULL,   31'd3},
            '{REQ_UNTIL, 8'hEF, 32'h0000_0003,  1, 1'b1, KIND_FULL,   31'd3},
            '{REQ_TICK,  8'h22, 32'h0000_0000,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_DELAY, 8'h60, 32'h7FFF_FFFF,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_UNTIL, 8'h61, 32'h7FFF_FFFF,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_DELAY, 8'h62, 32'h7FFF_FFFE,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_TIME,  8'h63, 32'h1234_5678,  1, 1'b0, KIND_ACK,    31'd0},
            '{REQ_TICK,  8'h64, 32'h0000_0000,  1, 1'b0, KIND_ACK,    31'd0}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int c = 0; c < directed_rows[r].copies; c++)
                send_request(directed_rows[r].op, 8'(directed_rows[r].who + c),
                             directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].exp_kind, directed_rows[r].exp_tick, 1'b0);
        end

        // Stretches with few ticks let the queue fill up; the others drain it.
        for (int i = 0; i < 200; i++) begin
            calm = ((i / 30) % 4 == 3);
            tick_share = ((i / 40) % 2 == 1) ? 8 : 35;
            roll = $urandom_range(0, 99);
            who = 8'($urandom_range(0, 255));
            if (roll < tick_share) begin
                op = REQ_TICK;
                value = $urandom;
            end else if (roll < tick_share + 8) begin
                op = REQ_TIME;
                value = $urandom;
            end else if (roll < 75) begin
                op = REQ_DELAY;
                value = 32'($urandom_range(0, 15));
            end else if (roll < 88) begin
                op = REQ_UNTIL;
                value = {1'b0, now_tick} + 32'($urandom_range(0, 14)) - 32'd2;
            end else if (roll < 94) begin
                op = REQ_DELAY;
                value = $urandom;
            end else begin
                op = REQ_UNTIL;
                value = $urandom;
            end
            send_request(op, who, value, 1'b0, KIND_ACK, '0,
                         i == 0 || $urandom_range(0, 49) == 0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0 && replies_due.size() == 0)
            $display("tick_delay_wakeup_queue_test passed");
        else
            $display("tick_delay_wakeup_queue_test failed");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tick_delay_wakeup_queue_test failed");
        $finish;
    end

endmodule
